FILE: rtl/core/qdec_pkg.sv
package qdec_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CSR_INDEX_W = 3;

   // Scale from steps per tick to degrees per second.
   localparam logic [DATA_W-1:0] SPEED_SCALE = 32'd27000000;

   localparam logic [1:0] ACTION_EDGE = 2'd0;
   localparam logic [1:0] ACTION_POLL = 2'd1;
   localparam logic [1:0] ACTION_RESET = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_PHASE_ERROR = 2'd1;
   localparam logic [1:0] STATUS_SPEED_UPDATED = 2'd2;
   localparam logic [1:0] STATUS_TIME_INVALID = 2'd3;

   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_BACKWARD = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_B = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_C = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_D = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS = 3'd4;

   typedef struct packed {
      logic take;       // an input item is accepted this cycle
      logic mul;        // register the step count times the scale
      logic div_load;   // load the divider and check for overflow
      logic div_step;   // one quotient bit
      logic speed_hold; // store the finished speed
      logic rsp_load;   // load the output register
   } qdec_cmd_type;

   typedef struct packed {
      logic speed_go;   // a poll now would recompute the speed
   } qdec_stat_type;

endpackage

FILE: rtl/core/qdec_if.sv
interface qdec_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [1:0]  pins;
   logic [31:0] now;

   modport source(output valid, action, pins, now, input ready);
   modport sink(input valid, action, pins, now, output ready);
endinterface

interface qdec_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] angle_tenths;
   logic [31:0]        speed_deg_per_s;
   logic [1:0]         direction;

   modport source(output valid, status, angle_tenths, speed_deg_per_s, direction,
                  input ready);
   modport sink(input valid, status, angle_tenths, speed_deg_per_s, direction,
                output ready);
endinterface

interface qdec_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/qdec_ctrl.sv
module qdec_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  qdec_pkg::qdec_stat_type stat,
   output qdec_pkg::qdec_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_SPD  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam int unsigned STEPS = qdec_pkg::DATA_W;
   localparam int unsigned CNT_W = $clog2(STEPS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      cmd.take = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_action == qdec_pkg::ACTION_POLL) begin
               state_in = stat.speed_go ? S_MUL : S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.div_load = 1'b1;
            count_in     = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == CNT_W'(STEPS - 1)) begin
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            cmd.speed_hold = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/qdec_dp.sv
module qdec_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  qdec_pkg::qdec_cmd_type  cmd,
   output qdec_pkg::qdec_stat_type stat,
   input  logic [1:0]              req_action,
   input  logic [1:0]              req_pins,
   input  logic [31:0]             req_now,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_angle_tenths,
   output logic [31:0]             rsp_speed_deg_per_s,
   output logic [1:0]              rsp_direction
);

   localparam int unsigned W = qdec_pkg::DATA_W;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_FORWARD  = 2'd1;
   localparam logic [1:0] KIND_BACKWARD = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   // Configuration.
   logic [1:0]   code_a_ff, code_b_ff, code_c_ff, code_d_ff;
   logic [W-1:0] window_ff;

   // Encoder state.
   logic [1:0]   last_phase_ff;
   logic [W-1:0] signed_steps_ff, total_steps_ff;
   logic         phase_error_ff;
   logic [W-1:0] window_start_ff, last_edge_ff, elapsed_ff;
   logic [W-1:0] steps_at_window_ff, steps_at_poll_ff, held_speed_ff;

   // Poll result staging and divider.
   logic [1:0]   res_status_ff, res_dir_ff;
   logic [W-1:0] res_angle_ff;
   logic [W-1:0] delta_ff, divisor_ff;
   logic [2*W-1:0] prod_ff;
   logic [W-1:0] rem_ff, quo_ff;
   logic         sat_ff;

   // Output register.
   logic [1:0]   out_status_ff, out_dir_ff;
   logic [W-1:0] out_angle_ff, out_speed_ff;

   logic [1:0]   kind;
   logic [1:0]   dir;
   logic [W+1:0] angle_wide;
   logic [W-1:0] angle_sat;
   logic         window_hit;
   logic [W:0]   trial;
   logic         trial_fits;

   always_comb begin
      kind = KIND_NONE;
      priority if (last_phase_ff == code_b_ff) begin
         priority if (req_pins == code_a_ff) kind = KIND_BACKWARD;
         else if (req_pins == code_c_ff) kind = KIND_FORWARD;
         else if (req_pins == code_d_ff) kind = KIND_ERROR;
         else kind = KIND_NONE;
      end else if (last_phase_ff == code_a_ff) begin
         priority if (req_pins == code_b_ff) kind = KIND_FORWARD;
         else if (req_pins == code_d_ff) kind = KIND_BACKWARD;
         else if (req_pins == code_c_ff) kind = KIND_ERROR;
         else kind = KIND_NONE;
      end else if (last_phase_ff == code_c_ff) begin
         priority if (req_pins == code_d_ff) kind = KIND_FORWARD;
         else if (req_pins == code_b_ff) kind = KIND_BACKWARD;
         else if (req_pins == code_a_ff) kind = KIND_ERROR;
         else kind = KIND_NONE;
      end else if (last_phase_ff == code_d_ff) begin
         priority if (req_pins == code_a_ff) kind = KIND_FORWARD;
         else if (req_pins == code_c_ff) kind = KIND_BACKWARD;
         else if (req_pins == code_b_ff) kind = KIND_ERROR;
         else kind = KIND_NONE;
      end else begin
         kind = KIND_NONE;
      end
   end

   // Angle is the signed count times three, clamped to the 32-bit signed range.
   always_comb begin
      angle_wide = {{2{signed_steps_ff[W-1]}}, signed_steps_ff}
                 + {signed_steps_ff[W-1], signed_steps_ff, 1'b0};
      if (!angle_wide[W+1] && angle_wide[W:W-1] != 2'b00) begin
         angle_sat = {1'b0, {(W-1){1'b1}}};
      end else if (angle_wide[W+1] && angle_wide[W:W-1] != 2'b11) begin
         angle_sat = {1'b1, {(W-1){1'b0}}};
      end else begin
         angle_sat = angle_wide[W-1:0];
      end
   end

   always_comb begin
      if ($signed(signed_steps_ff) > $signed(steps_at_poll_ff)) begin
         dir = qdec_pkg::DIR_FORWARD;
      end else if ($signed(signed_steps_ff) < $signed(steps_at_poll_ff)) begin
         dir = qdec_pkg::DIR_BACKWARD;
      end else begin
         dir = qdec_pkg::DIR_IDLE;
      end
   end

   assign window_hit    = (elapsed_ff >= window_ff);
   assign stat.speed_go = !phase_error_ff && window_hit && (elapsed_ff != '0);

   // With no overflow the remainder stays below the divisor; one shift-subtract per bit.
   assign trial      = {rem_ff, quo_ff[W-1]};
   assign trial_fits = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         code_a_ff          <= 2'd0;
         code_b_ff          <= 2'd1;
         code_c_ff          <= 2'd3;
         code_d_ff          <= 2'd2;
         window_ff          <= 32'd22500000;
         last_phase_ff      <= '0;
         signed_steps_ff    <= '0;
         total_steps_ff     <= '0;
         phase_error_ff     <= 1'b0;
         window_start_ff    <= '0;
         last_edge_ff       <= '0;
         elapsed_ff         <= '0;
         steps_at_window_ff <= '0;
         steps_at_poll_ff   <= '0;
         held_speed_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               qdec_pkg::CSR_PHASE_A:      code_a_ff <= csr_data[1:0];
               qdec_pkg::CSR_PHASE_B:      code_b_ff <= csr_data[1:0];
               qdec_pkg::CSR_PHASE_C:      code_c_ff <= csr_data[1:0];
               qdec_pkg::CSR_PHASE_D:      code_d_ff <= csr_data[1:0];
               qdec_pkg::CSR_WINDOW_TICKS: window_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.take) begin
            unique case (req_action)
               qdec_pkg::ACTION_EDGE: begin
                  last_edge_ff  <= req_now;
                  elapsed_ff    <= req_now - window_start_ff;
                  last_phase_ff <= req_pins;
                  unique case (kind)
                     KIND_FORWARD: begin
                        signed_steps_ff <= signed_steps_ff + 1'b1;
                        total_steps_ff  <= total_steps_ff + 1'b1;
                     end
                     KIND_BACKWARD: begin
                        signed_steps_ff <= signed_steps_ff - 1'b1;
                        total_steps_ff  <= total_steps_ff + 1'b1;
                     end
                     KIND_ERROR: phase_error_ff <= 1'b1;
                     default: ;
                  endcase
               end
               qdec_pkg::ACTION_RESET: begin
                  last_phase_ff      <= req_pins;
                  signed_steps_ff    <= '0;
                  total_steps_ff     <= '0;
                  phase_error_ff     <= 1'b0;
                  elapsed_ff         <= '0;
                  steps_at_window_ff <= '0;
                  window_start_ff    <= req_now;
                  last_edge_ff       <= req_now;
               end
               qdec_pkg::ACTION_POLL: begin
                  if (!phase_error_ff) begin
                     steps_at_poll_ff <= signed_steps_ff;
                     if (stat.speed_go) begin
                        window_start_ff    <= last_edge_ff;
                        steps_at_window_ff <= total_steps_ff;
                        elapsed_ff         <= '0;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (cmd.speed_hold) begin
            held_speed_ff <= sat_ff ? {W{1'b1}} : quo_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take && req_action == qdec_pkg::ACTION_POLL) begin
         if (phase_error_ff) begin
            res_status_ff <= qdec_pkg::STATUS_PHASE_ERROR;
            res_angle_ff  <= '0;
            res_dir_ff    <= qdec_pkg::DIR_IDLE;
         end else begin
            res_angle_ff <= angle_sat;
            res_dir_ff   <= dir;
            if (!window_hit) begin
               res_status_ff <= qdec_pkg::STATUS_OK;
            end else if (elapsed_ff == '0) begin
               res_status_ff <= qdec_pkg::STATUS_TIME_INVALID;
            end else begin
               res_status_ff <= qdec_pkg::STATUS_SPEED_UPDATED;
            end
         end
         delta_ff   <= total_steps_ff - steps_at_window_ff;
         divisor_ff <= elapsed_ff;
      end
      if (cmd.mul) begin
         prod_ff <= delta_ff * qdec_pkg::SPEED_SCALE;
      end
      if (cmd.div_load) begin
         rem_ff <= prod_ff[2*W-1:W];
         quo_ff <= prod_ff[W-1:0];
         // A high half at or above the divisor means the quotient needs more than 32 bits.
         sat_ff <= (prod_ff[2*W-1:W] >= divisor_ff);
      end
      if (cmd.div_step) begin
         rem_ff <= trial_fits ? W'(trial - {1'b0, divisor_ff}) : trial[W-1:0];
         quo_ff <= {quo_ff[W-2:0], trial_fits};
      end
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_angle_ff  <= res_angle_ff;
         out_speed_ff  <= held_speed_ff;
         out_dir_ff    <= res_dir_ff;
      end
   end

   assign rsp_status          = out_status_ff;
   assign rsp_angle_tenths    = $signed(out_angle_ff);
   assign rsp_speed_deg_per_s = out_speed_ff;
   assign rsp_direction       = out_dir_ff;

endmodule

FILE: rtl/core/quadrature_decoder_with_speed.sv
// Channel   Direction  Payload                                         Handshake
// req_ch    in         action, pins, now                               valid/ready
// rsp_ch    out        status, angle_tenths, speed_deg_per_s, direction valid/ready
// csr_ch    in         index, data                                     valid/ready, always ready
//
// Edge, reset and unused action items finish when taken; a poll ends in an output load,
// after a multiply, a divider load and 32 divide steps when the speed is recomputed.
// The serial divider sets the worst case; only one item is in work at a time.
// Synchronous active-high reset restores the register defaults and clears all counters.
// A finished result waits in the output register while the next item is taken in; a poll
// behind it holds until that result is transferred.
module quadrature_decoder_with_speed (
   input logic       clock,
   input logic       reset,
   qdec_req_if.sink  req_ch,
   qdec_rsp_if.source rsp_ch,
   qdec_csr_if.sink  csr_ch
);

   qdec_pkg::qdec_cmd_type  cmd;
   qdec_pkg::qdec_stat_type stat;

   assign csr_ch.ready = 1'b1;

   qdec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   qdec_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_ch.action),
      .req_pins            (req_ch.pins),
      .req_now             (req_ch.now),
      .csr_write           (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .rsp_status          (rsp_ch.status),
      .rsp_angle_tenths    (rsp_ch.angle_tenths),
      .rsp_speed_deg_per_s (rsp_ch.speed_deg_per_s),
      .rsp_direction       (rsp_ch.direction)
   );

endmodule

FILE: dv/tb_quadrature_decoder_with_speed.sv
module tb_quadrature_decoder_with_speed;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 60;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 124;

   typedef enum {STEP_NONE, STEP_FWD, STEP_BACK, STEP_JUMP} step_kind_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] angle_tenths;
      logic [31:0]        speed_deg_per_s;
      logic [1:0]         direction;
   } poll_result_type;

   class poll_scoreboard;
      logic [1:0]  code_a, code_b, code_c, code_d;
      logic [31:0] window_ticks;
      logic [1:0]  last_phase;
      logic [31:0] signed_steps, total_steps;
      logic        phase_error;
      logic [31:0] window_start, last_edge_time, elapsed;
      logic [31:0] steps_at_window, steps_at_last_poll, held_speed;
      poll_result_type pending_polls[$];
      int errors;

      function new();
         code_a = 2'd0;
         code_b = 2'd1;
         code_c = 2'd3;
         code_d = 2'd2;
         window_ticks = 32'd22500000;
         last_phase = '0;
         signed_steps = '0;
         total_steps = '0;
         phase_error = 1'b0;
         window_start = '0;
         last_edge_time = '0;
         elapsed = '0;
         steps_at_window = '0;
         steps_at_last_poll = '0;
         held_speed = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] data);
         case (index)
            qdec_pkg::CSR_PHASE_A: code_a = data[1:0];
            qdec_pkg::CSR_PHASE_B: code_b = data[1:0];
            qdec_pkg::CSR_PHASE_C: code_c = data[1:0];
            qdec_pkg::CSR_PHASE_D: code_d = data[1:0];
            qdec_pkg::CSR_WINDOW_TICKS: window_ticks = data;
            default: ;
         endcase
      endfunction

      // With colliding codes the previous phase is matched as B, A, C, D; first match wins.
      function step_kind_type classify(logic [1:0] prev, logic [1:0] cur);
         if (prev == code_b) begin
            if (cur == code_a) return STEP_BACK;
            if (cur == code_c) return STEP_FWD;
            if (cur == code_d) return STEP_JUMP;
         end else if (prev == code_a) begin
            if (cur == code_b) return STEP_FWD;
            if (cur == code_d) return STEP_BACK;
            if (cur == code_c) return STEP_JUMP;
         end else if (prev == code_c) begin
            if (cur == code_d) return STEP_FWD;
            if (cur == code_b) return STEP_BACK;
            if (cur == code_a) return STEP_JUMP;
         end else if (prev == code_d) begin
            if (cur == code_a) return STEP_FWD;
            if (cur == code_c) return STEP_BACK;
            if (cur == code_b) return STEP_JUMP;
         end
         return STEP_NONE;
      endfunction

      function void take_item(logic [1:0] action, logic [1:0] pins, logic [31:0] stamp);
         step_kind_type kind;
         poll_result_type res;
         logic signed [31:0] cur_s, prev_s;
         logic signed [63:0] angle_wide;
         logic [63:0] quotient;
         case (action)
            qdec_pkg::ACTION_EDGE: begin
               last_edge_time = stamp;
               elapsed = stamp - window_start;
               kind = classify(last_phase, pins);
               case (kind)
                  STEP_FWD: begin
                     signed_steps = signed_steps + 1;
                     total_steps = total_steps + 1;
                  end
                  STEP_BACK: begin
                     signed_steps = signed_steps - 1;
                     total_steps = total_steps + 1;
                  end
                  STEP_JUMP: phase_error = 1'b1;
                  default: ;
               endcase
               last_phase = pins;
            end
            qdec_pkg::ACTION_RESET: begin
               last_phase = pins;
               signed_steps = '0;
               total_steps = '0;
               phase_error = 1'b0;
               elapsed = '0;
               steps_at_window = '0;
               window_start = stamp;
               last_edge_time = stamp;
            end
            qdec_pkg::ACTION_POLL: begin
               if (phase_error) begin
                  res.status = qdec_pkg::STATUS_PHASE_ERROR;
                  res.angle_tenths = '0;
                  res.speed_deg_per_s = held_speed;
                  res.direction = qdec_pkg::DIR_IDLE;
               end else begin
                  cur_s = signed_steps;
                  prev_s = steps_at_last_poll;
                  if (cur_s > prev_s) res.direction = qdec_pkg::DIR_FORWARD;
                  else if (cur_s < prev_s) res.direction = qdec_pkg::DIR_BACKWARD;
                  else res.direction = qdec_pkg::DIR_IDLE;
                  steps_at_last_poll = signed_steps;
                  angle_wide = cur_s * 64'sd3;
                  if (angle_wide > 64'sd2147483647) angle_wide = 64'sd2147483647;
                  if (angle_wide < -64'sd2147483648) angle_wide = -64'sd2147483648;
                  res.angle_tenths = angle_wide[31:0];
                  res.status = qdec_pkg::STATUS_OK;
                  if (elapsed >= window_ticks) begin
                     if (elapsed == 0) begin
                        res.status = qdec_pkg::STATUS_TIME_INVALID;
                     end else begin
                        quotient = ({32'd0, total_steps - steps_at_window} *
                                    {32'd0, qdec_pkg::SPEED_SCALE}) / {32'd0, elapsed};
                        held_speed = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                               : quotient[31:0];
                        window_start = last_edge_time;
                        steps_at_window = total_steps;
                        elapsed = '0;
                        res.status = qdec_pkg::STATUS_SPEED_UPDATED;
                     end
                  end
                  res.speed_deg_per_s = held_speed;
               end
               pending_polls.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_poll(poll_result_type got);
         poll_result_type want;
         if (pending_polls.size() == 0) begin
            $error("poll result with nothing predicted: status %0d angle %0d speed %0d dir %0d",
                   got.status, got.angle_tenths, got.speed_deg_per_s, got.direction);
            errors++;
            return;
         end
         want = pending_polls.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.angle_tenths !== want.angle_tenths) begin
            $error("angle_tenths: expected %0d, got %0d", want.angle_tenths, got.angle_tenths);
            errors++;
         end
         if (got.speed_deg_per_s !== want.speed_deg_per_s) begin
            $error("speed_deg_per_s: expected %0d, got %0d",
                   want.speed_deg_per_s, got.speed_deg_per_s);
            errors++;
         end
         if (got.direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, got.direction);
            errors++;
         end
      endfunction

      function int pending();
         return pending_polls.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   qdec_req_if req_ch();
   qdec_rsp_if rsp_ch();
   qdec_csr_if csr_ch();

   quadrature_decoder_with_speed dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   poll_scoreboard sb = new();

   int req_idle_pct = 30;
   int rsp_idle_pct = 72;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   logic [1:0]  ring [4];
   logic [31:0] window_cfg;
   logic [31:0] stamp;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = qdec_pkg::ACTION_EDGE;
      req_ch.pins = '0;
      req_ch.now = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   // The result side: check every transfer, and run a long hold-off when asked.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_poll({rsp_ch.status, rsp_ch.angle_tenths, rsp_ch.speed_deg_per_s,
                        rsp_ch.direction});
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (rsp_idle_pct == 0) || ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [1:0] action, input logic [1:0] pins,
                            input logic [31:0] now);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= action;
      req_ch.pins <= pins;
      req_ch.now <= now;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_item(action, pins, now);
   endtask

   // Edge items give no result, so the block may still be busy after the last poll arrives.
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs();
      logic [2:0]  index [5];
      logic [31:0] value [5];
      index = '{qdec_pkg::CSR_PHASE_A, qdec_pkg::CSR_PHASE_B, qdec_pkg::CSR_PHASE_C,
                qdec_pkg::CSR_PHASE_D, qdec_pkg::CSR_WINDOW_TICKS};
      value = '{32'(ring[0]), 32'(ring[1]), 32'(ring[2]), 32'(ring[3]), window_cfg};
      for (int i = 0; i < 5; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= index[i];
         csr_ch.data <= value[i];
         do @(posedge clock); while (!csr_ch.ready);
         sb.write_reg(index[i], value[i]);
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic void shuffle_ring();
      int j;
      logic [1:0] tmp;
      ring = '{2'd0, 2'd1, 2'd2, 2'd3};
      for (int i = 3; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = ring[i];
         ring[i] = ring[j];
         ring[j] = tmp;
      end
   endfunction

   initial begin
      int pick;
      int tick_max;
      logic [1:0] ring_pos;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default phase codes A=0, B=1, C=3, D=2 straight out of reset.
      send_item(qdec_pkg::ACTION_RESET, 2'd0, 32'd1000);
      send_item(qdec_pkg::ACTION_POLL, 2'd0, 32'd1000);
      send_item(qdec_pkg::ACTION_EDGE, 2'd1, 32'd1010);
      send_item(qdec_pkg::ACTION_EDGE, 2'd3, 32'd1020);
      send_item(qdec_pkg::ACTION_EDGE, 2'd2, 32'd1030);
      send_item(qdec_pkg::ACTION_EDGE, 2'd0, 32'd1040);
      send_item(qdec_pkg::ACTION_POLL, 2'd3, 32'd1045);
      send_item(qdec_pkg::ACTION_EDGE, 2'd2, 32'd1050);
      send_item(qdec_pkg::ACTION_EDGE, 2'd3, 32'd1060);
      send_item(qdec_pkg::ACTION_EDGE, 2'd3, 32'd1070);
      send_item(qdec_pkg::ACTION_POLL, 2'd0, 32'd1080);
      send_item(ACTION_UNUSED, 2'd3, 32'hFFFF_FFFF);
      // Past the default window, so this poll recomputes the speed.
      send_item(qdec_pkg::ACTION_EDGE, 2'd1, 32'd30001000);
      send_item(qdec_pkg::ACTION_POLL, 2'd1, 32'd30001000);
      send_item(qdec_pkg::ACTION_POLL, 2'd2, 32'd30001005);
      send_item(qdec_pkg::ACTION_EDGE, 2'd0, 32'hFFFF_FFFF);
      // A to C skips a phase and sets the sticky error.
      send_item(qdec_pkg::ACTION_EDGE, 2'd3, 32'd0);
      send_item(qdec_pkg::ACTION_POLL, 2'd0, 32'd2);
      send_item(qdec_pkg::ACTION_EDGE, 2'd1, 32'd5);
      send_item(qdec_pkg::ACTION_POLL, 2'd3, 32'd7);
      send_item(qdec_pkg::ACTION_RESET, 2'd3, 32'd0);
      send_item(qdec_pkg::ACTION_EDGE, 2'd2, 32'd9);
      send_item(qdec_pkg::ACTION_POLL, 2'd2, 32'hFFFF_FFFF);
      req_ch.valid <= 1'b0;
      wait_drained();

      stamp = $urandom;
      for (int phase = 1; phase <= 6; phase++) begin
         req_idle_pct = (phase <= 2) ? 30 : (phase <= 4) ? 72 : 0;
         rsp_idle_pct = (phase <= 2) ? 72 : (phase <= 4) ? 30 : 0;
         case (phase)
            1: begin
               ring = '{2'd0, 2'd1, 2'd3, 2'd2};
               window_cfg = 32'd1;
               tick_max = 3;
            end
            2: begin
               shuffle_ring();
               window_cfg = 32'd1000;
               tick_max = 60;
            end
            3: begin
               ring = '{2'd2, 2'd2, 2'd1, 2'd1};
               window_cfg = 32'd500;
               tick_max = 40;
            end
            4: begin
               ring = '{2'd3, 2'd3, 2'd3, 2'd3};
               window_cfg = 32'hFFFF_FFFF;
               tick_max = 1000000;
            end
            5: begin
               shuffle_ring();
               window_cfg = 32'd22500000;
               tick_max = 2000000;
            end
            default: begin
               foreach (ring[i]) ring[i] = 2'($urandom_range(3));
               window_cfg = $urandom_range(3000, 1);
               tick_max = 200;
            end
         endcase
         program_regs();
         if (phase == 5) hold_request = 1'b1;

         ring_pos = 2'($urandom_range(3));
         send_item(qdec_pkg::ACTION_RESET, ring[ring_pos], stamp);
         if (phase == 1) begin
            // Many steps within one tick drive the speed into saturation.
            repeat (170) begin
               ring_pos = ring_pos + 2'd1;
               send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            end
            stamp = stamp + 1;
            ring_pos = ring_pos + 2'd1;
            send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            send_item(qdec_pkg::ACTION_POLL, ring[ring_pos], stamp);
         end

         repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            stamp = stamp + $urandom_range(tick_max);
            if (pick < 55) begin
               ring_pos = ring_pos + 2'd1;
               send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            end else if (pick < 70) begin
               ring_pos = ring_pos - 2'd1;
               send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            end else if (pick < 73) begin
               send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            end else if (pick < 75) begin
               ring_pos = ring_pos + 2'd2;
               send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            end else if (pick < 79) begin
               send_item(qdec_pkg::ACTION_EDGE, 2'($urandom_range(3)), stamp);
            end else if (pick < 90) begin
               send_item(qdec_pkg::ACTION_POLL, 2'($urandom_range(3)), $urandom);
            end else if (pick < 95) begin
               ring_pos = 2'($urandom_range(3));
               send_item(qdec_pkg::ACTION_RESET, ring[ring_pos], stamp);
            end else if (pick < 97) begin
               send_item(ACTION_UNUSED, 2'($urandom_range(3)), $urandom);
            end else begin
               stamp = $urandom;
               ring_pos = ring_pos + 2'd1;
               send_item(qdec_pkg::ACTION_EDGE, ring[ring_pos], stamp);
            end
         end
         send_item(qdec_pkg::ACTION_POLL, ring[ring_pos], stamp);
         req_ch.valid <= 1'b0;
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
